@@ rtl/lssr_pkg.sv @@
// Shared types and constants of the light-seeking servo ramp.
`timescale 1ns / 1ps
`default_nettype none
package lssr_pkg;

  localparam int SAMPLE_W = 12;
  localparam int POS_W    = 16;
  localparam int COUNT_W  = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POS_FIRST  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_POS_SECOND = 3'd4;

  localparam logic [SAMPLE_W-1:0] RESET_THRESHOLD  = 12'd2048;
  localparam logic [SAMPLE_W-1:0] RESET_TOLERANCE  = 12'd20;
  localparam logic [COUNT_W-1:0]  RESET_INTERVAL   = 8'd10;
  localparam logic [POS_W-1:0]    RESET_POS_FIRST  = 16'd250;
  localparam logic [POS_W-1:0]    RESET_POS_SECOND = 16'd1250;
  localparam logic [POS_W-1:0]    POS_CENTER       = 16'd750;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_first;
    logic [SAMPLE_W-1:0] sample_second;
  } samples_t;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             moving;
    logic             lit_first;
    logic             lit_second;
  } result_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] light_threshold;
    logic [SAMPLE_W-1:0] tolerance;
    logic [COUNT_W-1:0]  check_interval;
    logic [POS_W-1:0]    pos_first_brighter;
    logic [POS_W-1:0]    pos_second_brighter;
  } cfg_t;

endpackage
`default_nettype wire

@@ rtl/light_seeking_servo_ramp_top.sv @@
// Top level of the light-seeking servo ramp: input stage, ramp core, result stage.
`timescale 1ns / 1ps
`default_nettype none
// Each request is one tick with two light samples and yields one result: the
// servo position, the moving flag and the two lit indicators from the last
// decision. A request is taken every cycle unless sample_stall holds it; its
// result passes through the input register, then the result register. The ramp
// state updates once per request: one request per clock when nothing stalls.
// Configuration registers reset to their defaults and are to be written by the
// user only while no request is in flight; the block does not enforce this.
module light_seeking_servo_ramp_top
  import lssr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  sample_valid,
  output logic                       sample_stall,
  input  wire samples_t              samples,
  output logic                       result_valid,
  input  wire logic                  result_stall,
  output result_t                    result,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t     cfg;
  samples_t held;
  logic     held_valid;
  logic     advance;
  result_t  core_result;

  assign advance      = held_valid && (!result_valid || !result_stall);
  assign sample_stall = held_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (sample_valid && !sample_stall) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid && !sample_stall) begin
      held <= samples;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= core_result;
    end
  end

  lssr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lssr_core u_core (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .samples (held),
    .cfg     (cfg),
    .result  (core_result)
  );

endmodule
`default_nettype wire

@@ rtl/lssr_cfg.sv @@
// Configuration register file of the light-seeking servo ramp.
`timescale 1ns / 1ps
`default_nettype none
module lssr_cfg
  import lssr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                       cfg
);

  cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.light_threshold     <= RESET_THRESHOLD;
      regs.tolerance           <= RESET_TOLERANCE;
      regs.check_interval      <= RESET_INTERVAL;
      regs.pos_first_brighter  <= RESET_POS_FIRST;
      regs.pos_second_brighter <= RESET_POS_SECOND;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_THRESHOLD:  regs.light_threshold     <= cfg_data[SAMPLE_W-1:0];
        REG_TOLERANCE:  regs.tolerance           <= cfg_data[SAMPLE_W-1:0];
        REG_INTERVAL:   regs.check_interval      <= cfg_data[COUNT_W-1:0];
        REG_POS_FIRST:  regs.pos_first_brighter  <= cfg_data;
        REG_POS_SECOND: regs.pos_second_brighter <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule
`default_nettype wire

@@ rtl/lssr_core.sv @@
// Ramp state and its per-tick update: decision, step and periodic sensor check.
`timescale 1ns / 1ps
`default_nettype none
module lssr_core
  import lssr_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     step,
  input  wire samples_t samples,
  input  wire cfg_t     cfg,
  output result_t       result
);

  logic [POS_W-1:0]   position, position_next;
  logic [POS_W-1:0]   target, target_next;
  logic               active, active_next;
  logic [COUNT_W-1:0] steps, steps_next;
  logic               ind_first, ind_first_next;
  logic               ind_second, ind_second_next;

  logic [SAMPLE_W-1:0] diff;
  logic                lit1, lit2;
  logic [POS_W-1:0]    pick;
  logic [COUNT_W-1:0]  steps_inc;

  always_comb begin
    lit1 = samples.sample_first > cfg.light_threshold;
    lit2 = samples.sample_second > cfg.light_threshold;
    diff = (samples.sample_first > samples.sample_second)
         ? samples.sample_first - samples.sample_second
         : samples.sample_second - samples.sample_first;
    if (samples.sample_first > samples.sample_second) begin
      pick = cfg.pos_first_brighter;
    end else if (samples.sample_first < samples.sample_second) begin
      pick = cfg.pos_second_brighter;
    end else begin
      pick = POS_CENTER;
    end
    steps_inc = steps + 1'b1;

    position_next   = position;
    target_next     = target;
    active_next     = active;
    steps_next      = steps;
    ind_first_next  = ind_first;
    ind_second_next = ind_second;

    if (!active) begin
      // decision tick: latch indicators, maybe start a ramp, do not move
      ind_first_next  = lit1;
      ind_second_next = lit2;
      if (diff >= cfg.tolerance && pick != position) begin
        target_next = pick;
        active_next = 1'b1;
        steps_next  = '0;
      end
    end else begin
      if (position < target) begin
        position_next = position + 1'b1;
      end else if (position > target) begin
        position_next = position - 1'b1;
      end
      steps_next = steps_inc;
      if (position_next == target) begin
        active_next = 1'b0;
      end else if (steps_inc >= cfg.check_interval) begin
        // stop when one sensor alone is lit or the pair is balanced
        if (lit1 != lit2 || diff <= cfg.tolerance) begin
          active_next = 1'b0;
        end else begin
          steps_next = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position   <= POS_CENTER;
      target     <= POS_CENTER;
      active     <= 1'b0;
      steps      <= '0;
      ind_first  <= 1'b0;
      ind_second <= 1'b0;
    end else if (step) begin
      position   <= position_next;
      target     <= target_next;
      active     <= active_next;
      steps      <= steps_next;
      ind_first  <= ind_first_next;
      ind_second <= ind_second_next;
    end
  end

  assign result.position   = position_next;
  assign result.moving     = active_next;
  assign result.lit_first  = ind_first_next;
  assign result.lit_second = ind_second_next;

  a_active_not_at_target: assert property (@(posedge clk) disable iff (rst)
    active |-> position != target)
    else $error("ramp active while already at target");

  a_decision_holds_position: assert property (@(posedge clk) disable iff (rst)
    step && !active |=> position == $past(position))
    else $error("position moved on a decision tick");

  a_ramp_single_step: assert property (@(posedge clk) disable iff (rst)
    step && active |=> (position == $past(position) + 16'd1 ||
                        position == $past(position) - 16'd1))
    else $error("ramp step was not exactly one");

  a_indicators_hold_in_ramp: assert property (@(posedge clk) disable iff (rst)
    step && active |=> ind_first == $past(ind_first) && ind_second == $past(ind_second))
    else $error("indicators changed during a ramp");

endmodule
`default_nettype wire

@@ verif/tb_light_seeking_servo_ramp_top.sv @@
// Self-checking testbench for the light-seeking servo ramp top level.
`timescale 1ns / 1ps
module tb_light_seeking_servo_ramp_top;
  import lssr_pkg::*;

  localparam int IDLE_LIMIT   = 3000;
  localparam int LATENCY_WAIT = 8;
  localparam int SAMPLE_MAX   = (1 << SAMPLE_W) - 1;
  localparam int POS_MAX      = (1 << POS_W) - 1;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  sample_valid = 1'b0;
  logic                  sample_stall;
  samples_t              samples = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  result_t               result;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_THRESHOLD;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  light_seeking_servo_ramp_top dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .samples      (samples),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Mirror of the controller: settings and ramp state
  logic [SAMPLE_W-1:0] lit_level;
  logic [SAMPLE_W-1:0] balance_band;
  logic [COUNT_W-1:0]  steps_per_check;
  logic [POS_W-1:0]    goal_first;
  logic [POS_W-1:0]    goal_second;
  logic [POS_W-1:0]    servo_pos;
  logic [POS_W-1:0]    ramp_goal;
  logic                ramping;
  logic [COUNT_W-1:0]  stride_count;
  logic                lit1_held;
  logic                lit2_held;

  result_t readings_due[$];

  bit pace_inputs   = 1'b1;
  bit stall_results = 1'b1;
  int idle_cycles   = 0;
  int mismatches    = 0;
  int ticks_sent    = 0;
  int readings_seen = 0;
  int ramps_started = 0;
  int goals_reached = 0;
  int sensor_stops  = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Advance the servo mirror by one tick and return the reading it should report.
  function automatic result_t advance_servo(samples_t s);
    logic [SAMPLE_W-1:0] a;
    logic [SAMPLE_W-1:0] b;
    logic [SAMPLE_W-1:0] spread;
    logic [POS_W-1:0]    goal;
    logic                l1;
    logic                l2;
    result_t             r;
    a = s.sample_first;
    b = s.sample_second;
    spread = (a > b) ? a - b : b - a;
    l1 = a > lit_level;
    l2 = b > lit_level;
    if (!ramping) begin
      lit1_held = l1;
      lit2_held = l2;
      goal = POS_CENTER;
      if (a > b) goal = goal_first;
      else if (a < b) goal = goal_second;
      if (spread >= balance_band && goal != servo_pos) begin
        ramp_goal = goal;
        ramping = 1'b1;
        stride_count = '0;
        ramps_started++;
      end
    end else begin
      if (servo_pos < ramp_goal) servo_pos = servo_pos + 1'b1;
      else if (servo_pos > ramp_goal) servo_pos = servo_pos - 1'b1;
      stride_count = stride_count + 1'b1;
      if (servo_pos == ramp_goal) begin
        ramping = 1'b0;
        goals_reached++;
      end else if (stride_count >= steps_per_check) begin
        // stop when one sensor alone is lit or the pair is balanced
        if (l1 != l2 || spread <= balance_band) begin
          ramping = 1'b0;
          sensor_stops++;
        end else begin
          stride_count = '0;
        end
      end
    end
    r.position   = servo_pos;
    r.moving     = ramping;
    r.lit_first  = lit1_held;
    r.lit_second = lit2_held;
    return r;
  endfunction

  function automatic samples_t sample_pair(int a, int b);
    samples_t s;
    s.sample_first  = SAMPLE_W'(a);
    s.sample_second = SAMPLE_W'(b);
    return s;
  endfunction

  function automatic int corner_level();
    case ($urandom_range(0, 4))
      0: return 0;
      1: return SAMPLE_MAX;
      2: return int'(lit_level);
      3: return (lit_level == SAMPLE_MAX) ? SAMPLE_MAX : int'(lit_level) + 1;
      default: return $urandom_range(0, SAMPLE_MAX);
    endcase
  endfunction

  // Samples that keep a ramp alive at a check: same lit state, spread above the band.
  function automatic samples_t steady_pair();
    int       lo;
    int       hi;
    samples_t s;
    s = sample_pair(0, 0);
    for (int k = 0; k < 40; k++) begin
      if ($urandom_range(0, 1) == 1 && lit_level != SAMPLE_MAX) begin
        lo = int'(lit_level) + 1;
        hi = SAMPLE_MAX;
      end else begin
        lo = 0;
        hi = int'(lit_level);
      end
      s = sample_pair($urandom_range(lo, hi), $urandom_range(lo, hi));
      if ((s.sample_first > lit_level) == (s.sample_second > lit_level) &&
          ((s.sample_first > s.sample_second) ?
           s.sample_first - s.sample_second : s.sample_second - s.sample_first)
          > balance_band)
        return s;
    end
    return s;
  endfunction

  function automatic samples_t decision_pair();
    int a;
    int d;
    int pick;
    pick = $urandom_range(0, 99);
    a = $urandom_range(0, SAMPLE_MAX);
    if (pick < 60) return sample_pair(a, $urandom_range(0, SAMPLE_MAX));
    if (pick < 80) return sample_pair(corner_level(), corner_level());
    if (pick < 90) return sample_pair(a, a);
    // spread close to the balance band
    d = $urandom_range(0, int'(balance_band) + 2);
    if ($urandom_range(0, 1) == 1) d = -d;
    d = a + d;
    if (d < 0) d = 0;
    if (d > SAMPLE_MAX) d = SAMPLE_MAX;
    return sample_pair(a, d);
  endfunction

  function automatic logic [POS_W-1:0] near_pos(int offset);
    int p;
    p = int'(servo_pos) + offset;
    if (p < 0) p = 0;
    if (p > POS_MAX) p = POS_MAX;
    return POS_W'(p);
  endfunction

  function automatic int pick_gap();
    int pick;
    if (!pace_inputs) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    if (mismatches <= 30)
      $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $time);
  endtask

  // Present one request and hold it until the block takes it.
  task automatic send_tick(samples_t s);
    int gap;
    samples <= s;
    sample_valid <= 1'b1;
    do @(posedge clk); while (sample_stall);
    readings_due.push_back(advance_servo(s));
    ticks_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    sample_valid <= 1'b0;
    while (readings_due.size() != 0) @(posedge clk);
    repeat (LATENCY_WAIT) @(posedge clk);
  endtask

  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  // Drain the pipeline, then write all five registers back to back.
  task automatic program_regs(int thr, int tol, int intv, int pf, int ps);
    wait_idle();
    put_reg(REG_THRESHOLD, CFG_DATA_W'(thr));
    put_reg(REG_TOLERANCE, CFG_DATA_W'(tol));
    put_reg(REG_INTERVAL, CFG_DATA_W'(intv));
    put_reg(REG_POS_FIRST, CFG_DATA_W'(pf));
    put_reg(REG_POS_SECOND, CFG_DATA_W'(ps));
    cfg_we <= 1'b0;
    lit_level       = SAMPLE_W'(thr);
    balance_band    = SAMPLE_W'(tol);
    steps_per_check = COUNT_W'(intv);
    goal_first      = POS_W'(pf);
    goal_second     = POS_W'(ps);
  endtask

  // Mostly well-formed ramps: a decision, then ticks that usually survive the checks.
  task automatic run_random_phase(int n, int thr, int tol, int intv, int pf, int ps,
                                  bit paced);
    int pick;
    program_regs(thr, tol, intv, pf, ps);
    pace_inputs   = paced;
    stall_results = paced;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (!ramping) send_tick(decision_pair());
      else if (pick < 85) send_tick(steady_pair());
      else if (pick < 95)
        send_tick(sample_pair($urandom_range(0, SAMPLE_MAX), $urandom_range(0, SAMPLE_MAX)));
      else send_tick(sample_pair(corner_level(), corner_level()));
    end
    pace_inputs   = 1'b1;
    stall_results = 1'b1;
  endtask

  task automatic test_idle_decisions();
    send_tick(sample_pair(1000, 1000));
    send_tick(sample_pair(SAMPLE_MAX, SAMPLE_MAX));
    send_tick(sample_pair(0, 0));
    send_tick(sample_pair(2100, 2090));
    // one count above and exactly at the threshold
    send_tick(sample_pair(2049, 2048));
  endtask

  task automatic test_ramp_cases();
    program_regs(2048, 20, 2, 748, 753);
    // first brighter: ramp down two steps and stop on reaching the target
    repeat (3) send_tick(sample_pair(SAMPLE_MAX, 0));
    // target already equals the position: no ramp
    send_tick(sample_pair(SAMPLE_MAX, 0));
    // balanced at the check; indicators keep their decision values
    send_tick(sample_pair(0, SAMPLE_MAX));
    send_tick(sample_pair(0, SAMPLE_MAX));
    send_tick(sample_pair(3000, 3000));
    // spread exactly at the tolerance starts, then the first check stops it
    repeat (3) send_tick(sample_pair(2000, 2020));
    // only one sensor lit at the check
    repeat (3) send_tick(sample_pair(2200, 100));
  endtask

  task automatic test_interval_zero();
    program_regs(2048, 20, 0, 748, 753);
    repeat (4) send_tick(sample_pair(2100, SAMPLE_MAX));
  endtask

  task automatic test_default_random();
    run_random_phase(60, 2048, 20, 10, 250, 1250, 1'b1);
  endtask

  task automatic test_extreme_settings();
    run_random_phase(45, 0, 0, 1, near_pos(-6), near_pos(6), 1'b1);
    run_random_phase(30, SAMPLE_MAX, SAMPLE_MAX, 255, 0, POS_MAX, 1'b1);
    run_random_phase(30, SAMPLE_MAX, 0, 255, POS_MAX, 0, 1'b1);
    run_random_phase(30, 0, SAMPLE_MAX, 1, near_pos(-3), near_pos(3), 1'b1);
  endtask

  task automatic test_random_settings();
    int lo;
    int hi;
    for (int p = 0; p < 5; p++) begin
      lo = $urandom_range(0, 60);
      hi = $urandom_range(0, 60);
      if ($urandom_range(0, 1) == 1)
        run_random_phase(40, $urandom_range(0, SAMPLE_MAX), $urandom_range(0, 300),
                         $urandom_range(1, 16), near_pos(-lo), near_pos(hi), p != 2);
      else
        run_random_phase(40, $urandom_range(0, SAMPLE_MAX), $urandom_range(0, 300),
                         $urandom_range(1, 16), near_pos(hi), near_pos(-lo), p != 2);
    end
  endtask

  // Result side: random back-pressure with long free-running stretches.
  initial begin
    forever begin
      result_stall <= 1'b0;
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12))
        @(posedge clk);
      if (stall_results) begin
        result_stall <= 1'b1;
        repeat (($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3))
          @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : check_readings
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      readings_seen++;
      if (readings_due.size() == 0) begin
        report_mismatch("unexpected result, position", result.position, 0);
      end else begin
        want = readings_due.pop_front();
        if (result.position !== want.position)
          report_mismatch("position", result.position, want.position);
        if (result.moving !== want.moving)
          report_mismatch("moving", result.moving, want.moving);
        if (result.lit_first !== want.lit_first)
          report_mismatch("lit_first", result.lit_first, want.lit_first);
        if (result.lit_second !== want.lit_second)
          report_mismatch("lit_second", result.lit_second, want.lit_second);
      end
    end
  end

  always @(posedge clk) begin
    if ((sample_valid && !sample_stall) || (result_valid && !result_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("timeout: no request or result moved for %0d cycles", IDLE_LIMIT);
    $display("status: fail");
    $finish;
  end

  initial begin
    lit_level       = RESET_THRESHOLD;
    balance_band    = RESET_TOLERANCE;
    steps_per_check = RESET_INTERVAL;
    goal_first      = RESET_POS_FIRST;
    goal_second     = RESET_POS_SECOND;
    servo_pos       = POS_CENTER;
    ramp_goal       = POS_CENTER;
    ramping         = 1'b0;
    stride_count    = '0;
    lit1_held       = 1'b0;
    lit2_held       = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_idle_decisions();
    test_ramp_cases();
    test_interval_zero();
    test_default_random();
    test_extreme_settings();
    test_random_settings();

    wait_idle();
    while (readings_due.size() != 0) begin
      report_mismatch("missing result, position", 0, readings_due[0].position);
      void'(readings_due.pop_front());
    end
    $display("coverage: %0d ticks sent, %0d results checked, %0d mismatches",
             ticks_sent, readings_seen, mismatches);
    $display("ramps: %0d started, %0d reached target, %0d stopped by sensor check",
             ramps_started, goals_reached, sensor_stops);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/lssr_pkg.sv
rtl/lssr_cfg.sv
rtl/lssr_core.sv
rtl/light_seeking_servo_ramp_top.sv
verif/tb_light_seeking_servo_ramp_top.sv
